// ===== sv/assert_macros.svh =====
// Assertion macros used by the monitor unit RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("assertion failed");
`endif

// ===== sv/nmea_mon_pkg.sv =====
// Shared constants and types for the NMEA sentence monitor.
// No dependencies.
package nmea_mon_pkg;
    localparam int DEF_MAX_LINE      = 159;
    localparam int DEF_COUNTER_WIDTH = 32;

    localparam logic [2:0] OUT_EMPTY     = 3'd0;
    localparam logic [2:0] OUT_NO_DOLLAR = 3'd1;
    localparam logic [2:0] OUT_BAD_SUM   = 3'd2;
    localparam logic [2:0] OUT_SHORT     = 3'd3;
    localparam logic [2:0] OUT_KNOWN     = 3'd4;
    localparam logic [2:0] OUT_UNKNOWN   = 3'd5;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_RMC   = 3'd2;
    localparam logic [2:0] KIND_VTG   = 3'd3;
    localparam logic [2:0] KIND_GSA   = 3'd4;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_V      = 8'h56;

    // Numeric field accumulator: digits saturate at 255.
    typedef struct packed {
        logic       nonempty;
        logic       halted;
        logic [7:0] value;
    } numfield_t;

    // Line summary handed from the scanner to the classifier.
    typedef struct packed {
        logic [7:0]  line_length;
        logic        starts_dollar;
        logic        star_seen;
        logic [1:0]  hex_count;
        logic [7:0]  hex_value;
        logic        hex_bad;
        logic [7:0]  running_xor;
        logic        body_long;
        logic [23:0] type_letters;
        numfield_t   field_a;
        numfield_t   field_b;
        numfield_t   field_two;
        logic [7:0]  rmc_letter;
    } line_info_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic numfield_t feed_number(input numfield_t f, input logic [7:0] c);
        numfield_t  r;
        logic [11:0] acc;
        r = f;
        r.nonempty = 1'b1;
        acc = {4'd0, f.value} * 12'd10 + {8'd0, c[3:0]};
        if (!f.halted) begin
            if (c >= 8'h30 && c <= 8'h39) r.value = (acc > 12'd255) ? 8'd255 : acc[7:0];
            else r.halted = 1'b1;
        end
        return r;
    endfunction
endpackage

// ===== sv/nmea_sentence_monitor_unit.sv =====
// NMEA sentence monitor: one byte per beat, a registered result for each LF.
// The result is registered on the accepted LF beat and held until it is taken.
// Throughput: one byte every cycle while the result register is free or drains.
// Reset: synchronous active-low aresetn clears line state, held values, counters;
// min_satellites returns to 3 and the fix type to 1.
module nmea_sentence_monitor_unit #(
    parameter int MAX_LINE      = nmea_mon_pkg::DEF_MAX_LINE,
    parameter int COUNTER_WIDTH = nmea_mon_pkg::DEF_COUNTER_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [2:0]  m_sentence_kind,
    output logic [1:0]  m_fix_status,
    output logic [7:0]  m_satellites_now,
    output logic [7:0]  m_fix_quality_now,
    output logic [7:0]  m_fix_type_now,
    output logic        m_rmc_fix_ok_now,
    output logic [31:0] m_valid_total,
    output logic [31:0] m_bad_checksum_total,
    output logic [31:0] m_ignored_total,
    output logic [31:0] m_kind_total
);
    import nmea_mon_pkg::*;
`include "assert_macros.svh"

    localparam int CW = COUNTER_WIDTH;
    localparam logic [CW-1:0] CNT_ONE = {{(CW-1){1'b0}}, 1'b1};

    logic        accept, is_lf;
    line_info_t  info;

    // Accept unless a result is parked and not being taken this cycle.
    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_lf   = (s_rx_byte == CH_LF);

    nmea_mon_scan #(.MAX_LINE(MAX_LINE)) u_scan (
        .aclk(aclk), .aresetn(aresetn), .byte_en(accept),
        .rx_byte(s_rx_byte), .info(info)
    );

    logic [7:0]    min_sat_reg;
    logic [7:0]    sat_reg, sat_next, fq_reg, fq_next, ft_reg, ft_next;
    logic          rmc_reg, rmc_next;
    logic [1:0]    status_reg, status_next;
    logic [CW-1:0] cnt_valid_reg, cnt_bad_reg, cnt_ign_reg;
    logic [CW-1:0] cnt_valid_next, cnt_bad_next, cnt_ign_next;
    logic [CW-1:0] cnt_kind_reg [4];
    logic [CW-1:0] cnt_kind_next [4];
    logic [2:0]    outcome, kind;
    logic [CW-1:0] kind_total;
    logic          sum_ok;

    // Classify the finished line against the scanner summary.
    always_comb begin
        sat_next = sat_reg; fq_next = fq_reg; ft_next = ft_reg; rmc_next = rmc_reg;
        status_next = status_reg;
        cnt_valid_next = cnt_valid_reg; cnt_bad_next = cnt_bad_reg;
        cnt_ign_next = cnt_ign_reg;
        for (int i = 0; i < 4; i++) cnt_kind_next[i] = cnt_kind_reg[i];
        kind = KIND_OTHER;
        kind_total = '0;
        sum_ok = info.star_seen && (info.hex_count == 2'd2) && !info.hex_bad &&
                 (info.running_xor == info.hex_value);
        case (info.type_letters)
            24'h474741: kind = KIND_GGA;
            24'h524D43: kind = KIND_RMC;
            24'h565447: kind = KIND_VTG;
            24'h475341: kind = KIND_GSA;
            default:    kind = KIND_OTHER;
        endcase
        if (info.line_length == 8'd0) begin
            outcome = OUT_EMPTY; cnt_ign_next = cnt_ign_reg + CNT_ONE; kind = KIND_OTHER;
        end else if (!info.starts_dollar) begin
            outcome = OUT_NO_DOLLAR; cnt_ign_next = cnt_ign_reg + CNT_ONE; kind = KIND_OTHER;
        end else if (!sum_ok) begin
            outcome = OUT_BAD_SUM; cnt_bad_next = cnt_bad_reg + CNT_ONE; kind = KIND_OTHER;
        end else begin
            cnt_valid_next = cnt_valid_reg + CNT_ONE;
            if (!info.body_long) begin
                outcome = OUT_SHORT; cnt_ign_next = cnt_ign_reg + CNT_ONE; kind = KIND_OTHER;
            end else begin
                case (kind)
                    KIND_GGA: begin
                        fq_next  = info.field_a.nonempty ? info.field_a.value : 8'd0;
                        sat_next = info.field_b.nonempty ? info.field_b.value : 8'd0;
                    end
                    KIND_RMC: begin
                        if (info.rmc_letter == CH_A) rmc_next = 1'b1;
                        else if (info.rmc_letter == CH_V) rmc_next = 1'b0;
                    end
                    KIND_GSA: ft_next = info.field_two.nonempty ? info.field_two.value : 8'd1;
                    default: ;
                endcase
                if (kind == KIND_OTHER) begin
                    outcome = OUT_UNKNOWN; cnt_ign_next = cnt_ign_reg + CNT_ONE;
                end else begin
                    outcome = OUT_KNOWN;
                    // GSA lands in slot 3 because its low two code bits wrap to zero.
                    cnt_kind_next[kind[1:0] - 2'd1] = cnt_kind_reg[kind[1:0] - 2'd1] + CNT_ONE;
                    kind_total = cnt_kind_next[kind[1:0] - 2'd1];
                end
            end
            // Refresh status from the updated held values.
            if (ft_next == 8'd3) status_next = 2'd3;
            else if (ft_next == 8'd2) status_next = 2'd2;
            else if (fq_next != 8'd0 || rmc_next) status_next = 2'd2;
            else if (sat_next < min_sat_reg) status_next = 2'd1;
            else status_next = 2'd0;
        end
    end

    // The scanner summary is registered, so classify on the LF beat
    // using the summary as it stood before the LF (LF itself adds nothing).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_sat_reg <= 8'd3;
            sat_reg <= '0; fq_reg <= '0; ft_reg <= 8'd1; rmc_reg <= 1'b0;
            status_reg <= 2'd1;
            cnt_valid_reg <= '0; cnt_bad_reg <= '0; cnt_ign_reg <= '0;
            for (int i = 0; i < 4; i++) cnt_kind_reg[i] <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_we) min_sat_reg <= cfg_wdata;
            // Load a new result on the LF beat, otherwise drop it once taken.
            if (accept && is_lf) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            if (accept && is_lf) begin
                sat_reg <= sat_next; fq_reg <= fq_next; ft_reg <= ft_next;
                rmc_reg <= rmc_next; status_reg <= status_next;
                cnt_valid_reg <= cnt_valid_next; cnt_bad_reg <= cnt_bad_next;
                cnt_ign_reg <= cnt_ign_next;
                for (int i = 0; i < 4; i++) cnt_kind_reg[i] <= cnt_kind_next[i];
            end
        end
    end

    // Result register: payload only, loaded on each LF beat.
    always_ff @(posedge aclk) begin
        if (accept && is_lf) begin
            m_outcome            <= outcome;
            m_sentence_kind      <= kind;
            m_fix_status         <= status_next;
            m_satellites_now     <= sat_next;
            m_fix_quality_now    <= fq_next;
            m_fix_type_now       <= ft_next;
            m_rmc_fix_ok_now     <= rmc_next;
            m_valid_total        <= 32'(cnt_valid_next);
            m_bad_checksum_total <= 32'(cnt_bad_next);
            m_ignored_total      <= 32'(cnt_ign_next);
            m_kind_total         <= 32'(kind_total);
        end
    end

    `ASSERT_NEXT(a_lf_gives_result, aclk, aresetn, accept && is_lf, m_valid)
    `ASSERT_NEXT(a_no_result_other, aclk, aresetn, !(accept && is_lf) && !m_valid, !m_valid)
    `ASSERT_IMPLIES(a_kind_known, aclk, aresetn, m_valid && m_outcome == OUT_KNOWN,
        m_sentence_kind != KIND_OTHER)
endmodule

// ===== sv/nmea_mon_scan.sv =====
// Per-line running scanner: length, checksum, type letters and fields.
// Depends on nmea_mon_pkg.
module nmea_mon_scan #(
    parameter int MAX_LINE = nmea_mon_pkg::DEF_MAX_LINE
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     byte_en,
    input  logic [7:0]               rx_byte,
    output nmea_mon_pkg::line_info_t info
);
    import nmea_mon_pkg::*;

    line_info_t info_reg, info_next, cleared;
    logic       ended_reg, ended_next;
    logic [2:0] body_cnt_reg, body_cnt_next;
    logic [7:0] comma_reg, comma_next;
    logic [4:0] hd;
    logic [7:0] pos;

    assign info = info_reg;
    assign pos  = info_reg.line_length;
    assign hd   = hex_digit(rx_byte);

    always_comb begin
        cleared = '0;
        info_next = info_reg;
        ended_next = ended_reg;
        body_cnt_next = body_cnt_reg;
        comma_next = comma_reg;
        if (byte_en) begin
            if (rx_byte == CH_LF) begin
                info_next = cleared;
                ended_next = 1'b0;
                body_cnt_next = '0;
                comma_next = '0;
            end else if (!ended_reg && (32'(pos) < MAX_LINE)) begin
                if (rx_byte == CH_CR || rx_byte == CH_NUL) begin
                    ended_next = 1'b1;
                end else begin
                    info_next.line_length = pos + 8'd1;
                    if (pos == 8'd0) info_next.starts_dollar = (rx_byte == CH_DOLLAR);
                    if (info_reg.star_seen) begin
                        if (info_reg.hex_count < 2'd2) begin
                            if (hd[4]) info_next.hex_bad = 1'b1;
                            else info_next.hex_value = {info_reg.hex_value[3:0], hd[3:0]};
                            info_next.hex_count = info_reg.hex_count + 2'd1;
                        end
                    end else if (rx_byte == CH_STAR) begin
                        info_next.star_seen = 1'b1;
                    end else begin
                        if (body_cnt_reg < 3'd6) body_cnt_next = body_cnt_reg + 3'd1;
                        if (body_cnt_reg == 3'd5) info_next.body_long = 1'b1;
                        if (pos != 8'd0) info_next.running_xor = info_reg.running_xor ^ rx_byte;
                        if (pos >= 8'd3 && pos <= 8'd5)
                            info_next.type_letters = {info_reg.type_letters[15:0], rx_byte};
                        if (rx_byte == CH_COMMA) begin
                            if (comma_reg != 8'd255) comma_next = comma_reg + 8'd1;
                        end else begin
                            case (comma_reg)
                                8'd2: begin
                                    if (!info_reg.field_two.nonempty)
                                        info_next.rmc_letter = rx_byte;
                                    info_next.field_two = feed_number(info_reg.field_two, rx_byte);
                                end
                                8'd6: info_next.field_a = feed_number(info_reg.field_a, rx_byte);
                                8'd7: info_next.field_b = feed_number(info_reg.field_b, rx_byte);
                                default: ;
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            info_reg <= '0;
            ended_reg <= 1'b0;
            body_cnt_reg <= '0;
            comma_reg <= '0;
        end else begin
            info_reg <= info_next;
            ended_reg <= ended_next;
            body_cnt_reg <= body_cnt_next;
            comma_reg <= comma_next;
        end
    end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for nmea_sentence_monitor_unit.
// Depends on nmea_mon_pkg and the monitor RTL; feeds NMEA byte streams and checks
// every line result against a built-in line classifier.
module testbench;
    import nmea_mon_pkg::*;

    localparam int LINE_LIMIT = 159;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES = 1300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_outcome, m_sentence_kind;
    logic [1:0]  m_fix_status;
    logic [7:0]  m_satellites_now, m_fix_quality_now, m_fix_type_now;
    logic        m_rmc_fix_ok_now;
    logic [31:0] m_valid_total, m_bad_checksum_total, m_ignored_total, m_kind_total;

    nmea_sentence_monitor_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_outcome(m_outcome), .m_sentence_kind(m_sentence_kind),
        .m_fix_status(m_fix_status), .m_satellites_now(m_satellites_now),
        .m_fix_quality_now(m_fix_quality_now), .m_fix_type_now(m_fix_type_now),
        .m_rmc_fix_ok_now(m_rmc_fix_ok_now), .m_valid_total(m_valid_total),
        .m_bad_checksum_total(m_bad_checksum_total), .m_ignored_total(m_ignored_total),
        .m_kind_total(m_kind_total)
    );

    always #5 aclk = ~aclk;

    typedef struct {
        logic [2:0]  outcome;
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [7:0]  sats;
        logic [7:0]  quality;
        logic [7:0]  fix_type;
        logic        rmc_ok;
        logic [31:0] valid_cnt;
        logic [31:0] bad_cnt;
        logic [31:0] ignored_cnt;
        logic [31:0] kind_cnt;
    } line_result_t;

    typedef struct {
        bit       nonempty;
        bit       halted;
        int       value;
    } number_acc_t;

    // Directed stimulus row: a byte, and where obvious the outcome it closes with.
    typedef struct {
        logic [7:0] b;
        bit         typed;
        logic [2:0] outcome;
    } directed_row_t;

    line_result_t line_results_q[$];
    logic [7:0]   byte_q[$];
    int           fail_count = 0;
    int           quiet_cycles = 0;
    int           sender_idle_pct = 22;
    int           receiver_idle_pct = 75;

    // Classifier state: mirror of the per-line scanner and the committed values.
    logic [7:0]  min_sats;
    int          line_len, body_len, hex_count, commas;
    bit          content_done, has_dollar, has_star, hex_bad;
    logic [7:0]  hex_val, xor_sum, rmc_letter;
    logic [23:0] type_chars;
    number_acc_t field_a, field_b, field_two;
    logic [7:0]  sats_held, quality_held, fix_type_held;
    bit          rmc_held;
    logic [1:0]  status_held;
    logic [31:0] counters[7];

    function automatic number_acc_t feed_digit(input number_acc_t f, input logic [7:0] c);
        number_acc_t r;
        r = f;
        r.nonempty = 1'b1;
        if (!f.halted) begin
            if (c >= "0" && c <= "9") begin
                r.value = f.value * 10 + (c - "0");
                if (r.value > 255) r.value = 255;
            end else begin
                r.halted = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    task automatic clear_line_state();
        number_acc_t blank;
        blank = '{0, 0, 0};
        line_len = 0; content_done = 0; has_dollar = 0; has_star = 0;
        hex_count = 0; hex_val = 0; hex_bad = 0; xor_sum = 0; commas = 0;
        type_chars = 0; body_len = 0; rmc_letter = 0;
        field_a = blank; field_b = blank; field_two = blank;
    endtask

    task automatic reset_classifier();
        clear_line_state();
        min_sats = 8'd3;
        sats_held = 0; quality_held = 0; fix_type_held = 8'd1;
        rmc_held = 0; status_held = 2'd1;
        for (int i = 0; i < 7; i++) counters[i] = 0;
    endtask

    task automatic scan_content(input logic [7:0] c);
        int pos, d;
        pos = line_len;
        line_len++;
        if (pos == 0) has_dollar = (c == CH_DOLLAR);
        if (has_star) begin
            if (hex_count < 2) begin
                d = hex_nibble(c);
                if (d < 0) hex_bad = 1;
                else hex_val = {hex_val[3:0], d[3:0]};
                hex_count++;
            end
            return;
        end
        if (c == CH_STAR) begin
            has_star = 1;
            return;
        end
        body_len++;
        if (pos >= 1) xor_sum ^= c;
        if (pos >= 3 && pos <= 5) type_chars = {type_chars[15:0], c};
        if (c == CH_COMMA) begin
            if (commas < 255) commas++;
            return;
        end
        if (commas == 2) begin
            if (!field_two.nonempty) rmc_letter = c;
            field_two = feed_digit(field_two, c);
        end else if (commas == 6) begin
            field_a = feed_digit(field_a, c);
        end else if (commas == 7) begin
            field_b = feed_digit(field_b, c);
        end
    endtask

    // Advance the classifier by one byte; an LF closes the line and yields a result.
    task automatic classify_byte(input logic [7:0] c, output bit got, output line_result_t r);
        logic [2:0] outcome, kind;
        int slot;
        got = 0;
        kind = KIND_OTHER;
        r.kind_cnt = 0;
        if (c != CH_LF) begin
            if (content_done || line_len >= LINE_LIMIT) return;
            if (c == CH_CR || c == CH_NUL) begin
                content_done = 1;
                return;
            end
            scan_content(c);
            return;
        end
        if (line_len == 0) begin
            outcome = OUT_EMPTY; counters[2]++;
        end else if (!has_dollar) begin
            outcome = OUT_NO_DOLLAR; counters[2]++;
        end else if (!has_star || hex_count < 2 || hex_bad || xor_sum != hex_val) begin
            outcome = OUT_BAD_SUM; counters[1]++;
        end else begin
            counters[0]++;
            if (body_len < 6) begin
                outcome = OUT_SHORT; counters[2]++;
            end else begin
                if (type_chars == "GGA") kind = KIND_GGA;
                else if (type_chars == "RMC") kind = KIND_RMC;
                else if (type_chars == "VTG") kind = KIND_VTG;
                else if (type_chars == "GSA") kind = KIND_GSA;
                if (kind == KIND_GGA) begin
                    quality_held = field_a.nonempty ? 8'(field_a.value) : 8'd0;
                    sats_held = field_b.nonempty ? 8'(field_b.value) : 8'd0;
                end else if (kind == KIND_RMC) begin
                    if (rmc_letter == CH_A) rmc_held = 1;
                    else if (rmc_letter == CH_V) rmc_held = 0;
                end else if (kind == KIND_GSA) begin
                    fix_type_held = field_two.nonempty ? 8'(field_two.value) : 8'd1;
                end
                if (kind == KIND_OTHER) begin
                    outcome = OUT_UNKNOWN; counters[2]++;
                end else begin
                    outcome = OUT_KNOWN;
                    slot = 2 + kind;
                    counters[slot]++;
                    r.kind_cnt = counters[slot];
                end
            end
            if (fix_type_held == 3) status_held = 2'd3;
            else if (fix_type_held == 2) status_held = 2'd2;
            else if (quality_held > 0 || rmc_held) status_held = 2'd2;
            else if (sats_held < min_sats) status_held = 2'd1;
            else status_held = 2'd0;
        end
        r.outcome = outcome; r.kind = kind; r.status = status_held;
        r.sats = sats_held; r.quality = quality_held; r.fix_type = fix_type_held;
        r.rmc_ok = rmc_held; r.valid_cnt = counters[0]; r.bad_cnt = counters[1];
        r.ignored_cnt = counters[2];
        got = 1;
        clear_line_state();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        $display("mismatch %s: got %0d expected %0d", what, got_v, exp_v);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got_v,
                               input logic [31:0] exp_v);
        if (got_v !== exp_v) report_mismatch(what, got_v, exp_v);
    endtask

    // Result side: random backpressure, compare each result beat with the oldest line.
    always @(posedge aclk) begin
        line_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (line_results_q.size() == 0) begin
                report_mismatch("unexpected result beat", {29'd0, m_outcome}, 32'd0);
            end else begin
                e = line_results_q.pop_front();
                check_field("outcome", 32'(m_outcome), 32'(e.outcome));
                check_field("sentence_kind", 32'(m_sentence_kind), 32'(e.kind));
                check_field("fix_status", 32'(m_fix_status), 32'(e.status));
                check_field("satellites_now", 32'(m_satellites_now), 32'(e.sats));
                check_field("fix_quality_now", 32'(m_fix_quality_now), 32'(e.quality));
                check_field("fix_type_now", 32'(m_fix_type_now), 32'(e.fix_type));
                check_field("rmc_fix_ok_now", 32'(m_rmc_fix_ok_now), 32'(e.rmc_ok));
                check_field("valid_total", m_valid_total, e.valid_cnt);
                check_field("bad_checksum_total", m_bad_checksum_total, e.bad_cnt);
                check_field("ignored_total", m_ignored_total, e.ignored_cnt);
                check_field("kind_total", m_kind_total, e.kind_cnt);
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Present one byte after a random gap; return at the edge that takes it.
    task automatic send_byte(input logic [7:0] b, input bit typed, input logic [2:0] outcome);
        bit got;
        line_result_t r;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        classify_byte(b, got, r);
        if (got) begin
            if (typed && r.outcome != outcome)
                report_mismatch("directed outcome", 32'(r.outcome), 32'(outcome));
            line_results_q.push_back(r);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return "0" + n;
        return (lower ? "a" : "A") + (n - 10);
    endfunction

    // Queue one line: mostly well-formed sentences with random fields, some noise.
    task automatic queue_line();
        logic [7:0] body[$];
        string      kinds[5];
        string      k;
        logic [7:0] sum, c;
        int         nfields, flen, pick;
        bit         lower;
        kinds = '{"GGA", "RMC", "VTG", "GSA", "XYZ"};
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(20)) byte_q.push_back(8'($urandom_range(255)));
            byte_q.push_back(CH_LF);
            return;
        end
        body.push_back("G");
        body.push_back("P");
        pick = $urandom_range(4);
        k = kinds[pick];
        if ($urandom_range(7) == 0) k = "GxA";
        for (int i = 0; i < 3; i++) body.push_back(k[i]);
        nfields = $urandom_range(10);
        for (int f = 0; f < nfields; f++) begin
            body.push_back(CH_COMMA);
            case ($urandom_range(5))
                0: ;
                1: body.push_back($urandom_range(1) ? CH_A : CH_V);
                2: body.push_back(8'($urandom_range(32, 126)));
                3: begin
                    body.push_back("-");
                    body.push_back("0" + 8'($urandom_range(9)));
                end
                default: begin
                    flen = ($urandom_range(5) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 2);
                    for (int i = 0; i < flen; i++) begin
                        c = "0" + 8'($urandom_range(3));
                        if ($urandom_range(15) == 0) c = ".";
                        body.push_back(c);
                    end
                end
            endcase
        end
        // Occasionally stretch past the line limit.
        if ($urandom_range(40) == 0) repeat (170) body.push_back("9");
        sum = 0;
        foreach (body[i]) begin
            if (body[i] == CH_STAR) body[i] = "+";
            sum ^= body[i];
        end
        if ($urandom_range(7) == 0) sum ^= 8'd1 << $urandom_range(7);
        byte_q.push_back(CH_DOLLAR);
        foreach (body[i]) byte_q.push_back(body[i]);
        if ($urandom_range(19) != 0) begin
            byte_q.push_back(CH_STAR);
            lower = 1'($urandom_range(1));
            byte_q.push_back(hex_char(sum[7:4], lower));
            if ($urandom_range(19) == 0) byte_q.push_back("g");
            else byte_q.push_back(hex_char(sum[3:0], 1'($urandom_range(1))));
            if ($urandom_range(9) == 0) byte_q.push_back(8'($urandom_range(255)) | 8'h80);
        end
        if ($urandom_range(2) == 0) begin
            byte_q.push_back($urandom_range(1) ? CH_CR : CH_NUL);
            if ($urandom_range(3) == 0) byte_q.push_back("J");
        end
        byte_q.push_back(CH_LF);
    endtask

    // Hold the input idle until every line result has drained, then write the register.
    task automatic write_min_sats(input logic [7:0] value);
        s_valid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        min_sats = value;
    endtask

    directed_row_t directed[17] = '{
        '{CH_LF, 1, OUT_EMPTY},
        '{"x", 0, 0}, '{CH_LF, 1, OUT_NO_DOLLAR},
        '{CH_DOLLAR, 0, 0}, '{CH_STAR, 0, 0}, '{CH_LF, 1, OUT_BAD_SUM},
        '{CH_DOLLAR, 0, 0}, '{"A", 0, 0}, '{CH_STAR, 0, 0},
        '{"4", 0, 0}, '{"1", 0, 0}, '{CH_LF, 1, OUT_SHORT},
        '{8'hFF, 0, 0}, '{CH_NUL, 0, 0}, '{CH_CR, 0, 0}, '{"q", 0, 0},
        '{CH_LF, 1, OUT_NO_DOLLAR}
    };

    initial begin
        logic [7:0] cfg_values[3];
        int         idle_pairs[3][2];
        reset_classifier();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows run under the reset value of the register.
        foreach (directed[i]) send_byte(directed[i].b, directed[i].typed, directed[i].outcome);

        cfg_values = '{8'd0, 8'd255, 8'($urandom_range(1, 254))};
        idle_pairs = '{'{22, 75}, '{75, 22}, '{0, 0}};
        for (int p = 0; p < 3; p++) begin
            write_min_sats(cfg_values[p]);
            sender_idle_pct = idle_pairs[p][0];
            receiver_idle_pct = idle_pairs[p][1];
            while (byte_q.size() < RANDOM_BYTES / 3) queue_line();
            while (byte_q.size() != 0) send_byte(byte_q.pop_front(), 0, 0);
        end
        s_valid <= 1'b0;

        // Drain the remaining results, then give the block its latency.
        while (line_results_q.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
